>>> rtl/per_key_top_k_similarity_table_macros.svh
// Assertion macros used by the table's engine.
`ifndef PER_KEY_TOP_K_SIMILARITY_TABLE_MACROS_SVH
`define PER_KEY_TOP_K_SIMILARITY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PKTK_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pktk assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PKTK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pktk assertion failed");

`endif

>>> rtl/pktk_pkg.sv
// ----------------------------------------------------------------------------
// pktk_pkg
// Types and fixed constants of the per-key top-K similarity table.
// ----------------------------------------------------------------------------
package pktk_pkg;

    localparam int ROW_ID_W = 10;
    localparam int ID_W     = 16;
    localparam int SIM_W    = 16;
    localparam int CFG_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CFG_W-1:0] MAX_WIDTH_RESET = 5'd16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Register index as decoded from paddr[2].
    localparam logic REG_MAX_WIDTH = 1'b0;

    typedef struct packed {
        logic                    opcode;
        logic [ROW_ID_W-1:0]     row_id;
        logic [ID_W-1:0]         entry_id;
        logic signed [SIM_W-1:0] similarity;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic [ID_W-1:0]         entry_id_res;
        logic signed [SIM_W-1:0] similarity_res;
        logic                    last;
    } rsp_t;

    // Classified request as it waits in the front queue.
    typedef struct packed {
        logic                    opcode;
        logic                    in_range;
        logic [ROW_ID_W-1:0]     row_id;
        logic [ID_W-1:0]         entry_id;
        logic signed [SIM_W-1:0] similarity;
    } job_t;

endpackage

>>> rtl/per_key_top_k_similarity_table.sv
// ----------------------------------------------------------------------------
// per_key_top_k_similarity_table
// Per-row top-K list of (id, similarity) pairs sorted by descending score.
//
//   Channel  Direction  Handshake              Payload
//   in       in         in_valid / in_ready    pktk_pkg::req_t
//   out      out        out_valid / out_ready  pktk_pkg::rsp_t
//   apb      in         psel/penable, pready   max_width at 0x0
//
// An insert reads one entry per cycle on its backward scan, then does the
// final write if the pair makes the list; a query streams the row's entries
// to the output while it is not stalled. The entry memory's single read port
// sets this pace.
// After reset the row table is cleared row by row; no request is
// taken during that pass. A stalled output holds the query stream in place.
// ----------------------------------------------------------------------------
module per_key_top_k_similarity_table #(
    parameter int NUM_ROWS  = 1024,
    parameter int MAX_WIDTH = 16,
    parameter int ID_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pktk_pkg::APB_AW-1:0]   paddr,
    input  logic [pktk_pkg::APB_DW-1:0]   pwdata,
    output logic [pktk_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pktk_pkg::req_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pktk_pkg::rsp_t                out_data
);

    logic [pktk_pkg::CFG_W-1:0] max_width_reg, max_width_next;
    pktk_pkg::job_t             job;
    logic                       job_valid;
    logic                       job_pop;
    logic                       clearing;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == pktk_pkg::REG_MAX_WIDTH);
    assign prdata  = reg_sel ? pktk_pkg::APB_DW'(max_width_reg) : '0;

    always_comb
    begin
        max_width_next = max_width_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            max_width_next = pwdata[pktk_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg <= pktk_pkg::MAX_WIDTH_RESET;
        end
        else
        begin
            max_width_reg <= max_width_next;
        end
    end

    pktk_front #(
        .NUM_ROWS (NUM_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (in_data),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .hold      (clearing),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop)
    );

    pktk_engine #(
        .NUM_ROWS  (NUM_ROWS),
        .MAX_WIDTH (MAX_WIDTH),
        .ID_BITS   (ID_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_width (max_width_reg),
        .job       (job),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .clearing  (clearing),
        .rsp       (out_data),
        .rsp_valid (out_valid),
        .rsp_ready (out_ready)
    );

endmodule

>>> rtl/pktk_ram.sv
// ----------------------------------------------------------------------------
// pktk_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pktk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pktk_front.sv
// ----------------------------------------------------------------------------
// pktk_front
// Accepts requests, marks rows outside the table, and queues them (2 deep).
// ----------------------------------------------------------------------------
module pktk_front #(
    parameter int NUM_ROWS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pktk_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_ready,
    input  logic           hold,
    output pktk_pkg::job_t job,
    output logic           job_valid,
    input  logic           job_pop
);

    pktk_pkg::job_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    pktk_pkg::job_t job_in;

    assign req_ready = (cnt_reg != 2'd2) && !hold;
    assign push      = req_valid && req_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    always_comb
    begin
        job_in.opcode     = req.opcode;
        job_in.in_range   = (int'(req.row_id) < NUM_ROWS);
        job_in.row_id     = req.row_id;
        job_in.entry_id   = req.entry_id;
        job_in.similarity = req.similarity;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = job_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, job_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/pktk_engine.sv
// ----------------------------------------------------------------------------
// pktk_engine
// Back end: clears the row table after reset, then runs inserts (backward
// scan with shift) and queries (entry stream) against the row memories.
// ----------------------------------------------------------------------------
`include "per_key_top_k_similarity_table_macros.svh"

module pktk_engine #(
    parameter int NUM_ROWS  = 1024,
    parameter int MAX_WIDTH = 16,
    parameter int ID_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pktk_pkg::CFG_W-1:0]      cfg_width,
    input  pktk_pkg::job_t                  job,
    input  logic                            job_valid,
    output logic                            job_pop,
    output logic                            clearing,
    output pktk_pkg::rsp_t                  rsp,
    output logic                            rsp_valid,
    input  logic                            rsp_ready
);

    localparam int RW  = $clog2(NUM_ROWS);
    localparam int IW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int MW  = 1 + CW;
    localparam int EW  = ID_BITS + pktk_pkg::SIM_W;
    localparam int EAW = RW + IW;
    localparam int ENT_DEPTH = NUM_ROWS << IW;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_META = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;
    localparam logic [2:0] S_QRY  = 3'd5;
    localparam logic [2:0] S_NF   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] clr_reg, clr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] fin_reg, fin_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          first_reg, first_next;
    logic          out_valid_reg, out_valid_next;
    pktk_pkg::rsp_t out_data_reg, out_data_next;

    logic           meta_we, meta_re;
    logic [RW-1:0]  meta_waddr;
    logic [MW-1:0]  meta_wdata, meta_rdata;
    logic           ent_we, ent_re;
    logic [EAW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0]  ent_wdata, ent_rdata;

    logic [RW-1:0]             row;
    logic [ID_BITS-1:0]        new_id;
    logic [ID_BITS-1:0]        e_id;
    logic signed [15:0]        e_sim;
    logic                      m_valid;
    logic [CW-1:0]             m_cnt;
    logic [CW-1:0]             w_eff;
    logic [6:0]                cfg_ext;
    logic                      out_free;

    assign row      = RW'(job.row_id);
    assign new_id   = ID_BITS'(job.entry_id);
    assign e_id     = ent_rdata[EW-1:pktk_pkg::SIM_W];
    assign e_sim    = signed'(ent_rdata[pktk_pkg::SIM_W-1:0]);
    assign m_valid  = meta_rdata[MW-1];
    assign m_cnt    = meta_rdata[CW-1:0];
    assign out_free = !out_valid_reg || rsp_ready;
    assign clearing = (state_reg == S_CLR);
    assign rsp      = out_data_reg;
    assign rsp_valid = out_valid_reg;

    // Effective width: register value saturated to 1..MAX_WIDTH.
    always_comb
    begin
        cfg_ext = {2'b00, cfg_width};
        if (cfg_ext == 7'd0)
        begin
            w_eff = CW'(1);
        end
        else if (cfg_ext > 7'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(cfg_ext);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_data_next  = out_data_reg;
        job_pop        = 1'b0;
        meta_we        = 1'b0;
        meta_waddr     = row;
        meta_wdata     = '0;
        meta_re        = 1'b0;
        ent_we         = 1'b0;
        ent_waddr      = {row, j_reg[IW-1:0]};
        ent_wdata      = {new_id, job.similarity};
        ent_re         = 1'b0;
        ent_raddr      = {row, j_reg[IW-1:0]};

        case (state_reg)
            S_CLR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == RW'(NUM_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    if (!job.in_range)
                    begin
                        if (job.opcode == pktk_pkg::OP_INSERT)
                        begin
                            job_pop = 1'b1;
                        end
                        else
                        begin
                            state_next = S_NF;
                        end
                    end
                    else
                    begin
                        meta_re    = 1'b1;
                        state_next = S_META;
                    end
                end
            end
            S_META:
            begin
                cnt_next = m_cnt;
                if (job.opcode == pktk_pkg::OP_INSERT)
                begin
                    if (!m_valid)
                    begin
                        ent_we     = 1'b1;
                        ent_waddr  = {row, IW'(0)};
                        meta_we    = 1'b1;
                        meta_wdata = {1'b1, CW'(1)};
                        job_pop    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        fin_next   = (m_cnt < w_eff) ? m_cnt + 1'b1 : m_cnt;
                        j_next     = m_cnt - 1'b1;
                        ent_re     = 1'b1;
                        ent_raddr  = {row, j_next[IW-1:0]};
                        first_next = 1'b1;
                        state_next = S_CHK;
                    end
                end
                else
                begin
                    if (!m_valid)
                    begin
                        state_next = S_NF;
                    end
                    else
                    begin
                        j_next     = '0;
                        ent_re     = 1'b1;
                        ent_raddr  = {row, IW'(0)};
                        state_next = S_QRY;
                    end
                end
            end
            S_CHK:
            begin
                // The row has room exactly when the final count grows.
                if (first_reg && !(fin_reg > cnt_reg || job.similarity > e_sim))
                begin
                    job_pop    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (e_sim <= job.similarity)
                begin
                    if ((j_reg + 1'b1) < fin_reg)
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = {row, IW'(j_reg + 1'b1)};
                        ent_wdata = ent_rdata;
                    end
                    first_next = 1'b0;
                    if (j_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        j_next    = j_reg - 1'b1;
                        ent_re    = 1'b1;
                        ent_raddr = {row, j_next[IW-1:0]};
                    end
                end
                else
                begin
                    pos_next   = j_reg + 1'b1;
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (pos_reg < fin_reg)
                begin
                    ent_we    = 1'b1;
                    ent_waddr = {row, pos_reg[IW-1:0]};
                end
                meta_we    = 1'b1;
                meta_wdata = {1'b1, fin_reg};
                job_pop    = 1'b1;
                state_next = S_IDLE;
            end
            S_QRY:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.found         = 1'b1;
                    out_data_next.entry_id_res  = pktk_pkg::ID_W'(e_id);
                    out_data_next.similarity_res = e_sim;
                    out_data_next.last          = ((j_reg + 1'b1) == cnt_reg);
                    if ((j_reg + 1'b1) == cnt_reg)
                    begin
                        job_pop    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next    = j_reg + 1'b1;
                        ent_re    = 1'b1;
                        ent_raddr = {row, j_next[IW-1:0]};
                    end
                end
            end
            S_NF:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{found: 1'b0, entry_id_res: '0,
                                       similarity_res: '0, last: 1'b1};
                    job_pop        = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        fin_reg      <= fin_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        first_reg    <= first_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    pktk_ram #(
        .WIDTH (MW),
        .DEPTH (NUM_ROWS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (row),
        .rdata (meta_rdata)
    );

    pktk_ram #(
        .WIDTH (EW),
        .DEPTH (ENT_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    `PKTK_ASSERT_NOW(a_no_pop_clearing, clk, rst_n, clearing, !job_pop)
    `PKTK_ASSERT_NOW(a_put_count_nonzero, clk, rst_n, state_reg == S_PUT, fin_reg != '0)
    `PKTK_ASSERT_NEXT(a_last_ends_query, clk, rst_n,
        state_reg == S_QRY && out_free && (j_reg + 1'b1) == cnt_reg, state_reg == S_IDLE)

endmodule
